/* src/esc_pkg.sv */
// Shared constants and types for the elevator scan controller.
package esc_pkg;

	// Default number of floors served by the car
	localparam int FLOORS_DEF = 9;

	// Field widths fixed by the word format
	localparam int FLOOR_W   = 4;
	localparam int PENDING_W = 9;

	// Command codes carried in an input word
	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// Flags produced by one scheduling step
	typedef struct packed {
		logic heading_up;
		logic stopped;
	} step_flags_t;

endpackage

/* src/esc_step.sv */
// Next-state logic of the SCAN scheduler for one request or tick word.
module esc_step import esc_pkg::*; #(
	parameter int FLOORS = FLOORS_DEF,
	parameter int PW     = 4
) (
	input  logic                cmd,
	input  logic [FLOOR_W-1:0]  floor,
	input  logic [FLOORS-1:0]   req,
	input  logic [PW-1:0]       pos,
	input  logic                up,
	output logic [FLOORS-1:0]   req_nxt,
	output logic [PW-1:0]       pos_nxt,
	output step_flags_t         flags
);

	logic [FLOORS-1:0] pos_dec;
	logic [FLOORS-1:0] move_dec;
	logic [FLOORS-1:0] up_mask;
	logic [FLOORS-1:0] dn_mask;
	logic [FLOORS-1:0] flr_dec;
	logic              dir;
	logic [PW-1:0]     pos_mv;

	// Decode car position and requested floor; build sweep masks
	always_comb begin
		for (int i = 0; i < FLOORS; i++) begin
			pos_dec[i] = (PW'(i) == pos);
			up_mask[i] = (PW'(i) >= pos);
			dn_mask[i] = (PW'(i) <= pos);
			flr_dec[i] = (int'(floor) == i);
		end
	end

	// Settle direction: turn down when nothing waits at or above the car
	assign dir = (up && ((req & up_mask) == '0)) ? 1'b0 : up;

	// Step one floor in the settled direction, holding at the ends
	always_comb begin
		if (dir) begin
			pos_mv = ((int'(pos) + 1) < FLOORS) ? pos + PW'(1) : pos;
		end else begin
			pos_mv = (pos != '0) ? pos - PW'(1) : pos;
		end
		for (int i = 0; i < FLOORS; i++) begin
			move_dec[i] = (PW'(i) == pos_mv);
		end
	end

	// Apply the word to the request mask, car position and heading
	always_comb begin
		req_nxt          = req;
		pos_nxt          = pos;
		flags.heading_up = up;
		flags.stopped    = 1'b0;
		if (cmd == CMD_REQUEST) begin
			req_nxt = req | flr_dec;
		end else if (req != '0) begin
			if (!dir && ((req & dn_mask) == '0)) begin
				// nothing below either: turn up and spend the tick
				flags.heading_up = 1'b1;
			end else begin
				flags.heading_up = dir;
				if ((req & pos_dec) != '0) begin
					req_nxt       = req & ~pos_dec;
					flags.stopped = 1'b1;
				end else begin
					pos_nxt = pos_mv;
					if ((req & move_dec) != '0) begin
						req_nxt       = req & ~move_dec;
						flags.stopped = 1'b1;
					end
				end
			end
		end
	end

endmodule

/* src/elevator_scan_controller.sv */
// Top level of the elevator scan controller: word registers, state and result register.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_stall      cmd, floor
//   result    out        result_valid / result_stall  car_floor, heading_up, stopped_here,
//                                                     pending
//
// Every word yields one result word on the port via the input register, then the result
// register; one word per cycle unless the result stalls. The input register feeds the step
// logic, whose result enters the output register in the same cycle as the car state update.
// Reset (arst_n low) empties both registers, clears all requests, puts the car at
// floor 1 heading up. A stalled result holds the input register; item_stall rises
// only while the input register is full and the result cannot drain.
module elevator_scan_controller import esc_pkg::*; #(
	parameter int FLOORS = FLOORS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 cmd,
	input  logic [FLOOR_W-1:0]   floor,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [FLOOR_W-1:0]   car_floor,
	output logic                 heading_up,
	output logic                 stopped_here,
	output logic [PENDING_W-1:0] pending
);

	localparam int PW = (FLOORS > 2) ? $clog2(FLOORS) : 1;

	logic               valid_s1;
	logic               cmd_s1;
	logic [FLOOR_W-1:0] floor_s1;
	logic               advance;

	logic [FLOORS-1:0]  req_q;
	logic [PW-1:0]      car_pos_q;
	logic               going_up_q;

	logic [FLOORS-1:0]  req_nxt;
	logic [PW-1:0]      pos_nxt;
	step_flags_t        flags;

	logic               result_valid_q;
	logic [FLOORS-1:0]  req_out_q;
	logic [PW-1:0]      pos_out_q;
	logic               up_out_q;
	logic               stopped_q;

	// Drain the input register whenever the result register is free or taken
	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;

	// Hold input word occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	// Capture input word payload
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1   <= cmd;
			floor_s1 <= floor;
		end
	end

	esc_step #(
		.FLOORS (FLOORS),
		.PW     (PW)
	) u_step (
		.cmd     (cmd_s1),
		.floor   (floor_s1),
		.req     (req_q),
		.pos     (car_pos_q),
		.up      (going_up_q),
		.req_nxt (req_nxt),
		.pos_nxt (pos_nxt),
		.flags   (flags)
	);

	// Advance car state when the word moves on to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q      <= '0;
			car_pos_q  <= PW'(1);
			going_up_q <= 1'b1;
		end else if (valid_s1 && advance) begin
			req_q      <= req_nxt;
			car_pos_q  <= pos_nxt;
			going_up_q <= flags.heading_up;
		end
	end

	// Hold result word occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	// Capture result word payload
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			req_out_q <= req_nxt;
			pos_out_q <= pos_nxt;
			up_out_q  <= flags.heading_up;
			stopped_q <= flags.stopped;
		end
	end

	assign result_valid = result_valid_q;
	assign heading_up   = up_out_q;
	assign stopped_here = stopped_q;

	// Fit car position to the floor field
	generate
		if (PW >= FLOOR_W) begin : g_pos_trunc
			assign car_floor = pos_out_q[FLOOR_W-1:0];
		end else begin : g_pos_ext
			assign car_floor = {{(FLOOR_W-PW){1'b0}}, pos_out_q};
		end
	endgenerate

	// Fit request mask to the pending field
	generate
		if (FLOORS >= PENDING_W) begin : g_req_trunc
			assign pending = req_out_q[PENDING_W-1:0];
		end else begin : g_req_ext
			assign pending = {{(PENDING_W-FLOORS){1'b0}}, req_out_q};
		end
	endgenerate

endmodule

/* src/esc_checker.sv */
// Port-level checks for the elevator scan controller, bound to the top level.
module esc_checker import esc_pkg::*; #(
	parameter int FLOORS = FLOORS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_stall,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic [FLOOR_W-1:0]   car_floor,
	input logic                 heading_up,
	input logic                 stopped_here,
	input logic [PENDING_W-1:0] pending
);

	// A stalled result word stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(car_floor) && $stable(pending)
			&& $stable(stopped_here) && $stable(heading_up))
		else $error("result payload changed while stalled");

	// A served floor no longer shows as pending
	a_served_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && stopped_here |-> ((pending >> car_floor) & PENDING_W'(1)) == '0)
		else $error("served floor still pending");

	// The car never leaves the shaft
	a_floor_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (FLOORS > 15) || (int'(car_floor) < FLOORS))
		else $error("car floor out of range");

	// Stall the input only behind a stalled result word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled with no result backpressure");

endmodule

bind elevator_scan_controller esc_checker #(.FLOORS(FLOORS)) u_esc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.car_floor    (car_floor),
	.heading_up   (heading_up),
	.stopped_here (stopped_here),
	.pending      (pending)
);
